>>> rtl/quaternion_from_two_vectors_assert.svh
// Assertion macros for the quaternion_from_two_vectors checker.
`ifndef QUATERNION_FROM_TWO_VECTORS_ASSERT_SVH
`define QUATERNION_FROM_TWO_VECTORS_ASSERT_SVH

// same-cycle implication
`define QFV_ASSERT_IMPLY(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define QFV_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/qfv_pkg.sv
// Shared constants, types and functions of the quaternion_from_two_vectors block.
package qfv_pkg;

  localparam int IN_WIDTH   = 16;
  localparam int OUT_WIDTH  = 16;
  localparam int COMP_W     = 16;
  localparam int IN_SHIFT   = (IN_WIDTH > COMP_W) ? IN_WIDTH - COMP_W : 0;
  localparam int FRAC       = OUT_WIDTH - 2;
  localparam int DIV_STEPS  = 2 * FRAC - 1;
  localparam int QW         = DIV_STEPS + 2;
  localparam int RW         = QW + (QW % 2);
  localparam int HSQ_STEPS  = RW / 2;
  localparam int SW         = FRAC + 1;
  localparam int SQW        = 2 * COMP_W;
  localparam int CW         = SQW + 1;
  localparam int MW         = SQW;
  localparam int PW         = 2 * SQW;
  localparam int ROOT_STEPS = PW / 2;
  localparam int AW         = SW + MW;
  localparam int S_TDATA_W  = ((6 * IN_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((4 * OUT_WIDTH + 7) / 8) * 8;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [CW-1:0]     cross_t;
  typedef logic [MW-1:0]            mag_t;
  typedef logic [PW-1:0]            wide_t;
  typedef logic [SW-1:0]            half_t;
  typedef logic signed [OUT_WIDTH-1:0] qout_t;

  typedef struct packed {
    comp_t vx, vy, vz, wx, wy, wz;
  } vecs_t;

  typedef struct packed {
    cross_t cx, cy, cz;
    cross_t d;
    logic   degen;
  } geo_t;

  typedef struct packed {
    geo_t  g;
    wide_t p;
    wide_t c2;
  } prod_t;

  typedef struct packed {
    geo_t g;
    mag_t m;
    mag_t cm;
  } root_t;

  typedef struct packed {
    cross_t cx, cy, cz;
    mag_t   cm;
    half_t  qs;
    half_t  s;
    logic   degen;
  } half_out_t;

  typedef struct packed {
    qout_t qs, qx, qy, qz;
    logic  degen;
  } quat_t;

  typedef struct packed {
    wide_t n;
    wide_t r;
  } sq_t;

  function automatic comp_t get_comp(input logic [IN_WIDTH-1:0] raw);
    logic signed [31:0] t;
    t = 32'(signed'(raw));
    t = t >>> IN_SHIFT;
    return t[COMP_W-1:0];
  endfunction

  function automatic mag_t abs_c(input cross_t x);
    logic [CW-1:0] t;
    t = x[CW-1] ? -x : x;
    return t[MW-1:0];
  endfunction

  // one digit of the bitwise integer square root
  function automatic sq_t sqrt_step(input wide_t n, input wide_t r, input wide_t b);
    wide_t t;
    sq_t   o;
    t = r + b;
    if (n >= t) begin
      o.n = n - t;
      o.r = (r >> 1) + b;
    end else begin
      o.n = n;
      o.r = r >> 1;
    end
    return o;
  endfunction

endpackage

>>> rtl/qfv_prod.sv
// Front end: cross product, dot product, squared norms and degenerate detect.
module qfv_prod import qfv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  in_valid_i,
  input  vecs_t vec_i,
  output logic  out_valid_o,
  output prod_t out_o
);

  logic [4:1] vld_q;
  logic signed [SQW-1:0] cr_q [6];
  logic signed [SQW-1:0] dt_q [3];
  logic signed [SQW-1:0] sv_q [3];
  logic signed [SQW-1:0] sw_q [3];
  cross_t cx_q, cy_q, cz_q, d_q;
  mag_t   nv_q, nw_q;
  geo_t   g3_q;
  wide_t  p3_q;
  wide_t  csq_q [3];
  logic   zero_q;
  prod_t  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q[0] <= SQW'(vec_i.vy) * SQW'(vec_i.wz);
      cr_q[1] <= SQW'(vec_i.vz) * SQW'(vec_i.wy);
      cr_q[2] <= SQW'(vec_i.vz) * SQW'(vec_i.wx);
      cr_q[3] <= SQW'(vec_i.vx) * SQW'(vec_i.wz);
      cr_q[4] <= SQW'(vec_i.vx) * SQW'(vec_i.wy);
      cr_q[5] <= SQW'(vec_i.vy) * SQW'(vec_i.wx);
      dt_q[0] <= SQW'(vec_i.vx) * SQW'(vec_i.wx);
      dt_q[1] <= SQW'(vec_i.vy) * SQW'(vec_i.wy);
      dt_q[2] <= SQW'(vec_i.vz) * SQW'(vec_i.wz);
      sv_q[0] <= SQW'(vec_i.vx) * SQW'(vec_i.vx);
      sv_q[1] <= SQW'(vec_i.vy) * SQW'(vec_i.vy);
      sv_q[2] <= SQW'(vec_i.vz) * SQW'(vec_i.vz);
      sw_q[0] <= SQW'(vec_i.wx) * SQW'(vec_i.wx);
      sw_q[1] <= SQW'(vec_i.wy) * SQW'(vec_i.wy);
      sw_q[2] <= SQW'(vec_i.wz) * SQW'(vec_i.wz);

      cx_q <= CW'(cr_q[0]) - CW'(cr_q[1]);
      cy_q <= CW'(cr_q[2]) - CW'(cr_q[3]);
      cz_q <= CW'(cr_q[4]) - CW'(cr_q[5]);
      d_q  <= CW'(dt_q[0]) + CW'(dt_q[1]) + CW'(dt_q[2]);
      nv_q <= mag_t'(sv_q[0]) + mag_t'(sv_q[1]) + mag_t'(sv_q[2]);
      nw_q <= mag_t'(sw_q[0]) + mag_t'(sw_q[1]) + mag_t'(sw_q[2]);

      g3_q.cx    <= cx_q;
      g3_q.cy    <= cy_q;
      g3_q.cz    <= cz_q;
      g3_q.d     <= d_q;
      g3_q.degen <= 1'b0;
      zero_q     <= (nv_q == '0) || (nw_q == '0);
      p3_q       <= PW'(nv_q) * PW'(nw_q);
      csq_q[0]   <= PW'(abs_c(cx_q)) * PW'(abs_c(cx_q));
      csq_q[1]   <= PW'(abs_c(cy_q)) * PW'(abs_c(cy_q));
      csq_q[2]   <= PW'(abs_c(cz_q)) * PW'(abs_c(cz_q));

      out_q.g.cx    <= g3_q.cx;
      out_q.g.cy    <= g3_q.cy;
      out_q.g.cz    <= g3_q.cz;
      out_q.g.d     <= g3_q.d;
      out_q.g.degen <= zero_q || ((csq_q[0] == '0) && (csq_q[1] == '0) && (csq_q[2] == '0));
      out_q.p       <= p3_q;
      out_q.c2      <= csq_q[0] + csq_q[1] + csq_q[2];
    end
  end

  assign out_valid_o = vld_q[4];
  assign out_o       = out_q;

endmodule

>>> rtl/qfv_root.sv
// Pipelined 64-bit square roots of the norm product and the squared cross norm.
module qfv_root import qfv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  in_valid_i,
  input  prod_t in_i,
  output logic  out_valid_o,
  output root_t out_o
);

  logic [ROOT_STEPS:1] vld_q;
  sq_t  a_q [ROOT_STEPS];
  sq_t  b_q [ROOT_STEPS];
  sq_t  a_d [ROOT_STEPS];
  sq_t  b_d [ROOT_STEPS];
  geo_t g_q [ROOT_STEPS];

  always_comb begin
    for (int i = 0; i < ROOT_STEPS; i++) begin
      if (i == 0) begin
        a_d[i] = sqrt_step(in_i.p, '0, wide_t'(1) << (PW - 2 - 2 * i));
        b_d[i] = sqrt_step(in_i.c2, '0, wide_t'(1) << (PW - 2 - 2 * i));
      end else begin
        a_d[i] = sqrt_step(a_q[i-1].n, a_q[i-1].r, wide_t'(1) << (PW - 2 - 2 * i));
        b_d[i] = sqrt_step(b_q[i-1].n, b_q[i-1].r, wide_t'(1) << (PW - 2 - 2 * i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ROOT_STEPS-1:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
      g_q[0] <= in_i.g;
      for (int i = 1; i < ROOT_STEPS; i++) begin
        g_q[i] <= g_q[i-1];
      end
    end
  end

  assign out_valid_o = vld_q[ROOT_STEPS];
  assign out_o.g     = g_q[ROOT_STEPS-1];
  assign out_o.m     = a_q[ROOT_STEPS-1].r[MW-1:0];
  assign out_o.cm    = b_q[ROOT_STEPS-1].r[MW-1:0];

endmodule

>>> rtl/qfv_half.sv
// Half-angle terms: (M+-d)/M fractions by restoring division, then square roots.
module qfv_half import qfv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  root_t     in_i,
  output logic      out_valid_o,
  output half_out_t out_o
);

  localparam int HL = 2 + DIV_STEPS + HSQ_STEPS;

  typedef struct packed {
    cross_t cx, cy, cz;
    mag_t   cm;
    logic   degen;
  } hp_t;

  typedef struct packed {
    mag_t          den;
    mag_t          ra, rb;
    logic [QW-1:0] qa, qb;
  } dv_t;

  typedef struct packed {
    logic [RW-1:0] na, ra, nb, rb;
  } hs_t;

  logic [HL:1]  vld_q;
  hp_t          pay_q [HL];
  logic [MW:0]  numa_q, numb_q;
  mag_t         den1_q;
  dv_t          dv_q [DIV_STEPS+1];
  dv_t          dv_d [DIV_STEPS+1];
  hs_t          hs_q [HSQ_STEPS];
  hs_t          hs_d [HSQ_STEPS];
  logic signed [CW+1:0] suma, sumb;

  always_comb begin
    suma = (CW+2)'(signed'({1'b0, in_i.m})) + (CW+2)'(in_i.g.d);
    sumb = (CW+2)'(signed'({1'b0, in_i.m})) - (CW+2)'(in_i.g.d);
  end

  // integer part of num/den (0..2) and remainder, then one quotient bit a stage
  always_comb begin
    logic ga2, ga1, gb2, gb1;
    logic [MW:0] ta, tb, r2a, r2b;
    ga2 = numa_q >= {den1_q, 1'b0};
    ga1 = numa_q >= {1'b0, den1_q};
    gb2 = numb_q >= {den1_q, 1'b0};
    gb1 = numb_q >= {1'b0, den1_q};
    ta  = ga2 ? numa_q - {den1_q, 1'b0} : (ga1 ? numa_q - {1'b0, den1_q} : numa_q);
    tb  = gb2 ? numb_q - {den1_q, 1'b0} : (gb1 ? numb_q - {1'b0, den1_q} : numb_q);
    dv_d[0].den = den1_q;
    dv_d[0].ra  = ta[MW-1:0];
    dv_d[0].rb  = tb[MW-1:0];
    dv_d[0].qa  = QW'({ga2, ga1 & ~ga2});
    dv_d[0].qb  = QW'({gb2, gb1 & ~gb2});
    for (int i = 1; i <= DIV_STEPS; i++) begin
      r2a = {dv_q[i-1].ra, 1'b0};
      r2b = {dv_q[i-1].rb, 1'b0};
      dv_d[i].den = dv_q[i-1].den;
      if (r2a >= {1'b0, dv_q[i-1].den}) begin
        r2a = r2a - {1'b0, dv_q[i-1].den};
        dv_d[i].qa = {dv_q[i-1].qa[QW-2:0], 1'b1};
      end else begin
        dv_d[i].qa = {dv_q[i-1].qa[QW-2:0], 1'b0};
      end
      if (r2b >= {1'b0, dv_q[i-1].den}) begin
        r2b = r2b - {1'b0, dv_q[i-1].den};
        dv_d[i].qb = {dv_q[i-1].qb[QW-2:0], 1'b1};
      end else begin
        dv_d[i].qb = {dv_q[i-1].qb[QW-2:0], 1'b0};
      end
      dv_d[i].ra = r2a[MW-1:0];
      dv_d[i].rb = r2b[MW-1:0];
    end
  end

  always_comb begin
    sq_t oa, ob;
    for (int j = 0; j < HSQ_STEPS; j++) begin
      if (j == 0) begin
        oa = sqrt_step(PW'(dv_q[DIV_STEPS].qa), '0, wide_t'(1) << (RW - 2 - 2 * j));
        ob = sqrt_step(PW'(dv_q[DIV_STEPS].qb), '0, wide_t'(1) << (RW - 2 - 2 * j));
      end else begin
        oa = sqrt_step(PW'(hs_q[j-1].na), PW'(hs_q[j-1].ra), wide_t'(1) << (RW - 2 - 2 * j));
        ob = sqrt_step(PW'(hs_q[j-1].nb), PW'(hs_q[j-1].rb), wide_t'(1) << (RW - 2 - 2 * j));
      end
      hs_d[j].na = oa.n[RW-1:0];
      hs_d[j].ra = oa.r[RW-1:0];
      hs_d[j].nb = ob.n[RW-1:0];
      hs_d[j].rb = ob.r[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[HL-1:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numa_q <= suma[MW:0];
      numb_q <= sumb[MW:0];
      den1_q <= in_i.m;
      dv_q   <= dv_d;
      hs_q   <= hs_d;
      pay_q[0].cx    <= in_i.g.cx;
      pay_q[0].cy    <= in_i.g.cy;
      pay_q[0].cz    <= in_i.g.cz;
      pay_q[0].cm    <= in_i.cm;
      pay_q[0].degen <= in_i.g.degen;
      for (int i = 1; i < HL; i++) begin
        pay_q[i] <= pay_q[i-1];
      end
    end
  end

  assign out_valid_o = vld_q[HL];
  assign out_o.cx    = pay_q[HL-1].cx;
  assign out_o.cy    = pay_q[HL-1].cy;
  assign out_o.cz    = pay_q[HL-1].cz;
  assign out_o.cm    = pay_q[HL-1].cm;
  assign out_o.degen = pay_q[HL-1].degen;
  assign out_o.qs    = hs_q[HSQ_STEPS-1].ra[SW-1:0];
  assign out_o.s     = hs_q[HSQ_STEPS-1].rb[SW-1:0];

endmodule

>>> rtl/qfv_axis.sv
// Vector part: S*|c_i| / C per axis by restoring division, sign and identity select.
module qfv_axis import qfv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      in_valid_i,
  input  half_out_t in_i,
  output logic      out_valid_o,
  output quat_t     out_o
);

  localparam int AL = SW + 2;

  typedef struct packed {
    logic [2:0] neg;
    half_t      qs;
    mag_t       cm;
    logic       degen;
  } ap_t;

  typedef struct packed {
    logic [2:0][MW-1:0] rem;
    logic [2:0][SW-1:0] low;
    logic [2:0][SW-1:0] quo;
  } ad_t;

  logic [AL:1]        vld_q;
  ap_t                ap_q [SW+1];
  logic [2:0][AW-1:0] prod_q;
  ad_t                ad_q [SW];
  ad_t                ad_d [SW];
  quat_t              out_q;
  mag_t               cabs [3];

  assign cabs[0] = abs_c(in_i.cx);
  assign cabs[1] = abs_c(in_i.cy);
  assign cabs[2] = abs_c(in_i.cz);

  always_comb begin
    logic [MW:0] r2;
    logic [MW-1:0] rem;
    logic [SW-1:0] low, quo;
    for (int j = 0; j < SW; j++) begin
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          rem = prod_q[l][AW-1:SW];
          low = prod_q[l][SW-1:0];
          quo = '0;
        end else begin
          rem = ad_q[j-1].rem[l];
          low = ad_q[j-1].low[l];
          quo = ad_q[j-1].quo[l];
        end
        r2 = {rem, low[SW-1]};
        if (r2 >= {1'b0, ap_q[j].cm}) begin
          r2 = r2 - {1'b0, ap_q[j].cm};
          ad_d[j].quo[l] = {quo[SW-2:0], 1'b1};
        end else begin
          ad_d[j].quo[l] = {quo[SW-2:0], 1'b0};
        end
        ad_d[j].rem[l] = r2[MW-1:0];
        ad_d[j].low[l] = low << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[AL-1:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        prod_q[l] <= AW'(in_i.s) * AW'(cabs[l]);
      end
      ap_q[0].neg   <= {in_i.cz[CW-1], in_i.cy[CW-1], in_i.cx[CW-1]};
      ap_q[0].qs    <= in_i.qs;
      ap_q[0].cm    <= in_i.cm;
      ap_q[0].degen <= in_i.degen;
      for (int j = 1; j <= SW; j++) begin
        ap_q[j] <= ap_q[j-1];
      end
      ad_q <= ad_d;
      if (ap_q[SW].degen) begin
        out_q.qs <= qout_t'(1) << FRAC;
        out_q.qx <= '0;
        out_q.qy <= '0;
        out_q.qz <= '0;
      end else begin
        out_q.qs <= qout_t'(ap_q[SW].qs);
        out_q.qx <= ap_q[SW].neg[0] ? -qout_t'(ad_q[SW-1].quo[0]) : qout_t'(ad_q[SW-1].quo[0]);
        out_q.qy <= ap_q[SW].neg[1] ? -qout_t'(ad_q[SW-1].quo[1]) : qout_t'(ad_q[SW-1].quo[1]);
        out_q.qz <= ap_q[SW].neg[2] ? -qout_t'(ad_q[SW-1].quo[2]) : qout_t'(ad_q[SW-1].quo[2]);
      end
      out_q.degen <= ap_q[SW].degen;
    end
  end

  assign out_valid_o = vld_q[AL];
  assign out_o       = out_q;

endmodule

>>> rtl/quaternion_from_two_vectors.sv
// Top level of the quaternion_from_two_vectors block.
// Takes two 3-D vectors per input beat and returns the unit quaternion that
// turns the first one onto the second.
// Input beat (s_axis): tdata holds v_x, v_y, v_z, w_x, w_y, w_z, signed Q2.13.
// Output beat (m_axis): tdata holds q_scalar, q_x, q_y, q_z, signed Q1.14;
// tuser is the degenerate flag (zero input or parallel vectors, identity out).
// Exactly one output beat per input beat, in order.
// Pipeline: products and norms, then 64-bit square roots (one digit per
// stage), then half-angle terms (setup, 27 fraction bits, 15 root digits),
// then the vector part (product, 15 quotient bits, output register).
// Throughput: one beat per cycle unless stalled; every stage is registered.
// All stages move together on one enable: s_axis_tready = !m_axis_tvalid ||
// m_axis_tready, so a receiver stall freezes the pipeline with nothing lost.
// Reset clears all valid bits; the pipeline comes up empty.
module quaternion_from_two_vectors import qfv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // v_x, v_y, v_z, w_x, w_y, w_z
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // q_scalar, q_x, q_y, q_z
  output logic                 m_axis_tuser    // degenerate
);

  logic      en;
  vecs_t     vec;
  logic      prod_vld, root_vld, half_vld, out_vld;
  prod_t     prod;
  root_t     root;
  half_out_t half;
  quat_t     quat;

  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  assign vec.vx = get_comp(s_axis_tdata[0*IN_WIDTH +: IN_WIDTH]);
  assign vec.vy = get_comp(s_axis_tdata[1*IN_WIDTH +: IN_WIDTH]);
  assign vec.vz = get_comp(s_axis_tdata[2*IN_WIDTH +: IN_WIDTH]);
  assign vec.wx = get_comp(s_axis_tdata[3*IN_WIDTH +: IN_WIDTH]);
  assign vec.wy = get_comp(s_axis_tdata[4*IN_WIDTH +: IN_WIDTH]);
  assign vec.wz = get_comp(s_axis_tdata[5*IN_WIDTH +: IN_WIDTH]);

  qfv_prod u_prod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s_axis_tvalid),
    .vec_i       (vec),
    .out_valid_o (prod_vld),
    .out_o       (prod)
  );

  qfv_root u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (prod_vld),
    .in_i        (prod),
    .out_valid_o (root_vld),
    .out_o       (root)
  );

  qfv_half u_half (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (root_vld),
    .in_i        (root),
    .out_valid_o (half_vld),
    .out_o       (half)
  );

  qfv_axis u_axis (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (half_vld),
    .in_i        (half),
    .out_valid_o (out_vld),
    .out_o       (quat)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = M_TDATA_W'({quat.qz, quat.qy, quat.qx, quat.qs});
  assign m_axis_tuser  = quat.degen;

endmodule

>>> rtl/qfv_check.sv
// Port-level checker for quaternion_from_two_vectors, bound to the top level.
`include "quaternion_from_two_vectors_assert.svh"

module qfv_check import qfv_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  localparam logic [M_TDATA_W-1:0] IDENT = M_TDATA_W'(1) << FRAC;
  localparam logic [OUT_WIDTH-1:0] ONE   = OUT_WIDTH'(1) << FRAC;

  logic [OUT_WIDTH-1:0] scalar;

  assign scalar = m_axis_tdata[OUT_WIDTH-1:0];

  `QFV_ASSERT_IMPLY(a_ready_rule, clk_i, rst_ni, s_axis_tvalid || !s_axis_tvalid,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output")
  `QFV_ASSERT_IMPLY(a_degen_ident, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata == IDENT, "degenerate beat is not the identity")
  `QFV_ASSERT_IMPLY(a_scalar_range, clk_i, rst_ni, m_axis_tvalid,
    !scalar[OUT_WIDTH-1] && (scalar <= ONE), "scalar part out of range")
  `QFV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled beat changed")

endmodule

bind quaternion_from_two_vectors qfv_check u_qfv_check (.*);

>>> tb/testbench.sv
// Self-checking testbench for quaternion_from_two_vectors: directed and random vector pairs.
`timescale 1ns / 1ps
module testbench;
  import qfv_pkg::*;

  typedef logic signed [15:0] comp6_t [6];

  typedef struct {
    logic signed [15:0] c [6];
    bit    typed;
    quat_t want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  quat_t pending_quats [$];
  int    errors = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    quiet_cycles = 0;

  quaternion_from_two_vectors dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic quat_t predict_rotation(comp6_t in);
    longint v [3], w [3], cr [3], d;
    longint unsigned nv, nw, p, c2, m, cm, dm, qs, s, t;
    quat_t q;
    for (int i = 0; i < 3; i++) begin
      v[i] = in[i];
      w[i] = in[3+i];
    end
    cr[0] = v[1]*w[2] - v[2]*w[1];
    cr[1] = v[2]*w[0] - v[0]*w[2];
    cr[2] = v[0]*w[1] - v[1]*w[0];
    d = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
    nv = 0; nw = 0; c2 = 0;
    for (int i = 0; i < 3; i++) begin
      nv += longint'(v[i]*v[i]);
      nw += longint'(w[i]*w[i]);
      c2 += longint'(cr[i]*cr[i]);
    end
    p = nv * nw;
    q = '0;
    if (p == 0 || c2 == 0) begin
      q.qs = 16'sd16384;
      q.degen = 1'b1;
      return q;
    end
    m = root64(p);
    cm = root64(c2);
    dm = (d < 0) ? -d : d;
    qs = root64(((m + dm) << DIV_STEPS) / m);
    s  = root64(((m - dm) << DIV_STEPS) / m);
    if (d < 0) begin
      t = qs; qs = s; s = t;
    end
    q.qs = qs[15:0];
    t = (s * longint'(cr[0] < 0 ? -cr[0] : cr[0])) / cm;
    q.qx = (cr[0] < 0) ? -t[15:0] : t[15:0];
    t = (s * longint'(cr[1] < 0 ? -cr[1] : cr[1])) / cm;
    q.qy = (cr[1] < 0) ? -t[15:0] : t[15:0];
    t = (s * longint'(cr[2] < 0 ? -cr[2] : cr[2])) / cm;
    q.qz = (cr[2] < 0) ? -t[15:0] : t[15:0];
    return q;
  endfunction

  task automatic send_pair(comp6_t c, bit typed, quat_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {c[5], c[4], c[3], c[2], c[1], c[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_quats.push_back(typed ? want : predict_rotation(c));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_quats.size() != 0) @(posedge clk_i);
  endtask

  // receiver, output checker and watchdog
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    quat_t got, exp_q;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
              m_axis_tdata[63:48], m_axis_tuser};
      if (pending_quats.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        exp_q = pending_quats.pop_front();
        if (got.qs != exp_q.qs) begin
          $error("q_scalar exp %0d got %0d", exp_q.qs, got.qs); errors++;
        end
        if (got.qx != exp_q.qx) begin
          $error("q_x exp %0d got %0d", exp_q.qx, got.qx); errors++;
        end
        if (got.qy != exp_q.qy) begin
          $error("q_y exp %0d got %0d", exp_q.qy, got.qy); errors++;
        end
        if (got.qz != exp_q.qz) begin
          $error("q_z exp %0d got %0d", exp_q.qz, got.qz); errors++;
        end
        if (got.degen != exp_q.degen) begin
          $error("degenerate exp %0d got %0d", exp_q.degen, got.degen); errors++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic comp6_t random_pair(int kind);
    comp6_t c;
    int k;
    case (kind)
      0: for (int i = 0; i < 6; i++) c[i] = $urandom;
      1: for (int i = 0; i < 6; i++) c[i] = $urandom_range(64) - 32;
      2, 3: begin
        k = $urandom_range(1, 7);
        if (kind == 3) k = -k;
        for (int i = 0; i < 3; i++) begin
          c[i] = $urandom_range(9362) - 4681;
          c[3+i] = c[i] * k;
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          c[i] = $urandom_range(8000) - 4000;
          c[3+i] = c[i] * 2 + $urandom_range(4) - 2;
        end
      end
    endcase
    return c;
  endfunction

  stim_row_t directed [] = '{
    '{'{0, 0, 0, 100, 200, 300},             1, '{16384, 0, 0, 0, 1}},
    '{'{100, -200, 300, 0, 0, 0},            1, '{16384, 0, 0, 0, 1}},
    '{'{0, 0, 0, 0, 0, 0},                   1, '{16384, 0, 0, 0, 1}},
    '{'{1000, 2000, 3000, 2000, 4000, 6000}, 1, '{16384, 0, 0, 0, 1}},
    '{'{1000, 2000, 3000, -1000, -2000, -3000}, 1, '{16384, 0, 0, 0, 1}},
    '{'{-32768, -32768, -32768, -32768, -32768, -32768}, 1, '{16384, 0, 0, 0, 1}},
    '{'{32767, 32767, 32767, -32768, -32768, -32768}, 1, '{16384, 0, 0, 0, 1}},
    '{'{8192, 0, 0, 0, 8192, 0},             0, '{0, 0, 0, 0, 0}},
    '{'{0, 8192, 0, 0, 0, 8192},             0, '{0, 0, 0, 0, 0}},
    '{'{0, 0, 8192, 8192, 0, 0},             0, '{0, 0, 0, 0, 0}},
    '{'{32767, 0, 0, 0, -32768, 0},          0, '{0, 0, 0, 0, 0}},
    '{'{-32768, 32767, -32768, 32767, -32768, 32767}, 0, '{0, 0, 0, 0, 0}},
    '{'{32767, -32768, 0, -32768, 32767, 1}, 0, '{0, 0, 0, 0, 0}},
    '{'{1, 0, 0, 0, 1, 0},                   0, '{0, 0, 0, 0, 0}},
    '{'{8192, 1, 0, -8192, 0, 0},            0, '{0, 0, 0, 0, 0}},
    '{'{-1, -1, -1, 1, 2, 3},                0, '{0, 0, 0, 0, 0}},
    '{'{5, 0, 0, 5, 1, 0},                   0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    comp6_t c;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[i]) begin
      for (int j = 0; j < 6; j++) c[j] = directed[i].c[j];
      send_pair(c, directed[i].typed, directed[i].want);
    end
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 36 : 78) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 36 : 78) : 0;
      for (int n = 0; n < 285; n++) begin
        c = random_pair($urandom_range(4));
        send_pair(c, 1'b0, '0);
      end
      drain();
    end
    repeat (120) @(posedge clk_i);
    if (errors == 0 && pending_quats.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
